// ----- rtl/core/fsp_pkg.sv -----
package fsp_pkg;

  localparam int PAD_MAX     = 16;
  localparam int PAD_W       = $clog2(PAD_MAX + 1);
  localparam int TABLE_DEPTH = 128;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_END  = 2'd1,
    MODE_TBL  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CAPACITY = 2'd1,
    ERR_HEADER   = 2'd2,
    ERR_NO_REC   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    REG_PAD_COUNT = 2'd0,
    REG_TERM_CODE = 2'd1,
    REG_CAPACITY  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

endpackage

// ----- rtl/core/fsp_if.sv -----
interface fsp_byte_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [7:0]        data_byte;
  logic [6:0]        table_index;
  logic signed [7:0] table_value;

  modport source (output valid, mode, data_byte, table_index, table_value, input ready);
  modport sink   (input valid, mode, data_byte, table_index, table_value, output ready);
endinterface

interface fsp_sym_if;
  logic        valid;
  logic        ready;
  logic [6:0]  symbol;
  logic        is_pad;
  logic [15:0] record_index;
  logic [31:0] position;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, symbol, is_pad, record_index, position, error_code, last,
                  input ready);
  modport sink   (input valid, symbol, is_pad, record_index, position, error_code, last,
                  output ready);
endinterface

// ----- rtl/core/fsp_ram.sv -----
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/fasta_stream_symbol_parser.sv -----
// FASTA byte stream to translated symbol stream.
//
// byte_in carries one beat per item: a FASTA byte (mode 0), end of input
// (mode 1) or a translation table write (mode 2, mode 3 is dropped).
// sym_out carries result beats; last marks the final beat of an item.
// cfg_we/cfg_index/cfg_data write pad_count, term_code and capacity.
//
// When a byte is accepted, its table entry is read from RAM at that edge;
// its beat then goes to the output register once sym_out is free.
// Throughput: one item per cycle for items with zero or one beat while
// sym_out does not stall. An item that opens a record or ends the input
// with padding holds byte_in not ready until its padding ends.
//
// Reset (rst, synchronous) clears phase and counters and loads register
// defaults; the table RAM is not cleared and must be written first.
// When sym_out stalls, the held item waits in the work stage and byte_in
// drops ready until that item can finish. After an error or end of input
// the block halts: bytes give no beats until reset, table writes still land.
module fasta_stream_symbol_parser
  import fsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fsp_byte_if.sink      byte_in,
  fsp_sym_if.source     sym_out,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SEQ    = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  // configuration
  logic [4:0]  pad_count;
  logic [6:0]  term_code;
  logic [31:0] capacity;

  // parse state
  phase_t      phase, phase_next;
  logic        prev_nl, prev_nl_next;
  logic [31:0] sym_cnt, sym_cnt_next;
  logic [15:0] rec_cnt, rec_cnt_next;

  // work stage
  logic             s1_valid;
  logic             s1_end;
  logic [7:0]       s1_byte;
  logic             pad_active, pad_active_next;
  logic [PAD_W-1:0] pad_left, pad_left_next;
  logic [PAD_W-1:0] padn;

  logic [7:0] tbl_rdata;
  logic       accept;
  logic       out_free;
  logic       finish;

  // beat being built this cycle
  logic        emit;
  logic [6:0]  e_sym;
  logic        e_pad;
  err_t        e_err;
  logic        e_last;

  assign out_free = !sym_out.valid || sym_out.ready;
  assign byte_in.ready = !s1_valid || finish;
  assign accept = byte_in.valid && byte_in.ready;

  always_comb begin
    if (32'(pad_count) > PAD_MAX) begin
      padn = PAD_W'(PAD_MAX);
    end else begin
      padn = PAD_W'(pad_count);
    end
  end

  fsp_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (accept && byte_in.mode == MODE_TBL),
    .waddr (TBL_AW'(byte_in.table_index)),
    .wdata (unsigned'(byte_in.table_value)),
    .re    (accept && byte_in.mode == MODE_BYTE),
    .raddr (TBL_AW'(byte_in.data_byte[6:0])),
    .rdata (tbl_rdata)
  );

  always_comb begin
    logic       want;
    logic [6:0] w_sym;
    logic       w_pad;
    logic       open_rec;

    want            = 1'b0;
    w_sym           = '0;
    w_pad           = 1'b0;
    open_rec        = 1'b0;
    phase_next      = phase;
    prev_nl_next    = prev_nl;
    sym_cnt_next    = sym_cnt;
    rec_cnt_next    = rec_cnt;
    pad_active_next = pad_active;
    pad_left_next   = pad_left;
    emit            = 1'b0;
    e_sym           = '0;
    e_pad           = 1'b0;
    e_err           = ERR_NONE;
    e_last          = 1'b1;
    finish          = 1'b0;

    if (s1_valid && out_free) begin
      if (pad_active) begin
        want  = 1'b1;
        w_sym = term_code;
        w_pad = 1'b1;
      end else begin
        finish = 1'b1;
        if (phase != PH_HALT) begin
          if (s1_end) begin
            unique case (phase)
              PH_SEEK: begin
                emit       = 1'b1;
                e_err      = ERR_NO_REC;
                phase_next = PH_HALT;
              end
              PH_HEADER: begin
                emit       = 1'b1;
                e_err      = ERR_HEADER;
                phase_next = PH_HALT;
              end
              default: begin
                // padding beats do not look at phase, so halt now
                phase_next = PH_HALT;
                if (sym_cnt != '0 && padn != '0) begin
                  pad_active_next = 1'b1;
                  pad_left_next   = padn;
                  finish          = 1'b0;
                end
              end
            endcase
          end else begin
            unique case (phase)
              PH_SEEK: begin
                open_rec = (s1_byte == CH_GT);
              end
              PH_HEADER: begin
                if (s1_byte == CH_NL) begin
                  phase_next   = PH_SEQ;
                  prev_nl_next = 1'b0;
                end
              end
              default: begin
                if (s1_byte == CH_GT && prev_nl) begin
                  open_rec = 1'b1;
                end else begin
                  if (!s1_byte[7] && !tbl_rdata[7]) begin
                    want  = 1'b1;
                    w_sym = tbl_rdata[6:0];
                  end
                  prev_nl_next = (s1_byte == CH_NL);
                end
              end
            endcase
          end
        end
      end
    end

    if (open_rec) begin
      if (rec_cnt != '1) begin
        rec_cnt_next = rec_cnt + 16'd1;
      end
      phase_next   = PH_HEADER;
      prev_nl_next = 1'b0;
      if (padn != '0) begin
        pad_active_next = 1'b1;
        pad_left_next   = padn;
        finish          = 1'b0;
      end
    end

    if (want) begin
      emit = 1'b1;
      if (sym_cnt >= capacity) begin
        e_err           = ERR_CAPACITY;
        phase_next      = PH_HALT;
        pad_active_next = 1'b0;
        finish          = 1'b1;
      end else begin
        e_sym        = w_sym;
        e_pad        = w_pad;
        sym_cnt_next = sym_cnt + 32'd1;
        if (w_pad) begin
          pad_left_next = pad_left - PAD_W'(1);
          e_last        = (pad_left == PAD_W'(1));
          if (pad_left == PAD_W'(1)) begin
            pad_active_next = 1'b0;
            finish          = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_count     <= '0;
      term_code     <= '0;
      capacity      <= '1;
      phase         <= PH_SEEK;
      prev_nl       <= 1'b0;
      sym_cnt       <= '0;
      rec_cnt       <= '0;
      s1_valid      <= 1'b0;
      pad_active    <= 1'b0;
      pad_left      <= '0;
      sym_out.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PAD_COUNT: pad_count <= cfg_data[4:0];
          REG_TERM_CODE: term_code <= cfg_data[6:0];
          REG_CAPACITY:  capacity  <= cfg_data;
          default: ;
        endcase
      end

      phase      <= phase_next;
      prev_nl    <= prev_nl_next;
      sym_cnt    <= sym_cnt_next;
      rec_cnt    <= rec_cnt_next;
      pad_active <= pad_active_next;
      pad_left   <= pad_left_next;

      // only bytes and end of input need the work stage
      if (accept && (byte_in.mode == MODE_BYTE || byte_in.mode == MODE_END)) begin
        s1_valid <= 1'b1;
        s1_end   <= (byte_in.mode == MODE_END);
        s1_byte  <= byte_in.data_byte;
      end else if (finish) begin
        s1_valid <= 1'b0;
      end

      if (emit) begin
        sym_out.valid        <= 1'b1;
        sym_out.symbol       <= e_sym;
        sym_out.is_pad       <= e_pad;
        sym_out.record_index <= rec_cnt;
        sym_out.position     <= sym_cnt;
        sym_out.error_code   <= e_err;
        sym_out.last         <= e_last;
      end else if (sym_out.ready) begin
        sym_out.valid <= 1'b0;
      end
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    sym_out.valid && sym_out.error_code != ERR_NONE |-> sym_out.last)
    else $error("error beat without last");

  a_pad_no_err: assert property (@(posedge clk) disable iff (rst)
    sym_out.valid && sym_out.is_pad |-> sym_out.error_code == ERR_NONE)
    else $error("pad beat carries an error");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("left halt without reset");

  a_pad_left: assert property (@(posedge clk) disable iff (rst)
    pad_active |-> s1_valid && pad_left != '0)
    else $error("padding with nothing left");

endmodule
